// ----- rtl/stbs_pkg.sv -----
`default_nettype none

package stbs_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int WORD_WIDTH_DEF  = 32;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CMP
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/sorted_table_binary_search.sv -----
`default_nettype none

// Sorted table with binary search.
//
// Items enter on start when busy is low. A load item (opcode OP_LOAD) writes
// word_value into the table at entry_index in the same cycle and gives no
// result; a load at an index past the table is dropped. A search item
// (opcode OP_SEARCH) looks for word_value between range_first and range_last,
// both inclusive, in a table that software keeps sorted in increasing signed
// order. The search gives one result on found and match_index, marked by a
// one-cycle done strobe; match_index is 0 when found is low.
// Each probe reads the table memory at the midpoint in ST_CHECK and then, in
// ST_CMP, compares the registered read data with the key. A search makes at
// most log2(TABLE_DEPTH)+1 probes. An empty range gives its result from
// ST_CHECK without a table read. busy is low in the done cycle, so the next
// item can be taken there.
// The receiver cannot stall; results are not held past their strobe cycle.
// Reset returns the controller to idle. Table entries are undefined until
// loaded and need no clearing after reset.

module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
	parameter int WORD_WIDTH  = stbs_pkg::WORD_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               opcode,
	input  wire logic [9:0]         entry_index,
	input  wire logic signed [31:0] word_value,
	input  wire logic [9:0]         range_first,
	input  wire logic signed [10:0] range_last,
	output logic                    done,
	output logic                    found,
	output logic [9:0]              match_index
);
	import stbs_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	// Bounds run from -1024 (range_last is signed) up to TABLE_DEPTH, and range_first may exceed the table.
	localparam int BW = ((AW > 10) ? AW : 10) + 2;
	localparam logic signed [BW-1:0] HI_MAX = BW'(TABLE_DEPTH - 1);
	localparam logic [WORD_WIDTH-1:0] SIGN_FLIP = {1'b1, {(WORD_WIDTH-1){1'b0}}};

	state_t state_q, state_d;

	logic [WORD_WIDTH-1:0] tbl_q [TABLE_DEPTH];
	logic [WORD_WIDTH-1:0] rdata_q;
	logic [WORD_WIDTH-1:0] key_q;
	logic [WORD_WIDTH-1:0] in_ordered;
	logic signed [BW-1:0]  lo_q, hi_q, mid_q;
	logic signed [BW-1:0]  first_ext, last_ext, last_clamped, mid;
	logic                  done_q, found_q;
	logic [9:0]            match_q;

	logic accept, load_we, init_en, probe_en, empty, hit, go_low, go_high, res_valid;

	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	// Offset binary lets an unsigned compare order the words as signed values.
	assign in_ordered = WORD_WIDTH'($unsigned(word_value)) ^ SIGN_FLIP;
	assign first_ext  = $signed(BW'(range_first));
	assign last_ext   = BW'(range_last);
	assign last_clamped = (last_ext > HI_MAX) ? HI_MAX : last_ext;
	assign empty      = (hi_q < lo_q);
	assign mid        = lo_q + ((hi_q - lo_q) >>> 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && opcode == OP_SEARCH) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = empty ? ST_IDLE : ST_CMP;
			end
			ST_CMP: begin
				state_d = (rdata_q == key_q) ? ST_IDLE : ST_CHECK;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		load_we   = 1'b0;
		init_en   = 1'b0;
		probe_en  = 1'b0;
		hit       = 1'b0;
		go_low    = 1'b0;
		go_high   = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				load_we = accept && (opcode == OP_LOAD) &&
					({22'd0, entry_index} < 32'(TABLE_DEPTH));
				init_en = accept && (opcode == OP_SEARCH);
			end
			ST_CHECK: begin
				probe_en  = !empty;
				res_valid = empty;
			end
			ST_CMP: begin
				hit       = (rdata_q == key_q);
				go_low    = (rdata_q > key_q);
				go_high   = (rdata_q < key_q);
				res_valid = hit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_we) tbl_q[AW'(entry_index)] <= in_ordered;
		if (probe_en) rdata_q <= tbl_q[mid[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (init_en) begin
			lo_q  <= first_ext;
			hi_q  <= last_clamped;
			key_q <= in_ordered;
		end
		if (probe_en) mid_q <= mid;
		if (go_low) hi_q <= mid_q - BW'(1);
		if (go_high) lo_q <= mid_q + BW'(1);
		if (res_valid) begin
			found_q <= hit;
			match_q <= hit ? 10'(mid_q) : 10'd0;
		end
	end

	assign done        = done_q;
	assign found       = found_q;
	assign match_index = match_q;

	a_done_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_CHECK || $past(state_q) == ST_CMP))
		else $error("result strobe without a search in progress");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (match_index == 10'd0))
		else $error("miss reported with a nonzero index");

	a_search_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_SEARCH) |=> busy)
		else $error("search item taken without going busy");

	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> ($past(state_q) == ST_CHECK))
		else $error("compare without a preceding memory read");

endmodule

`default_nettype wire
